[sv/huffman_symbol_encoder_core_macros.svh]
// assertion macros for the huffman symbol encoder core
// each macro expects clk and rst_n in the scope where it is used
`ifndef HUFFMAN_SYMBOL_ENCODER_CORE_MACROS_SVH
`define HUFFMAN_SYMBOL_ENCODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define HSE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hse check failed");
`define HSE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hse check failed");
`else
`define HSE_ASSERT_IMP(name, ante, cons)
`define HSE_ASSERT_NXT(name, ante, cons)
`endif

`endif

[sv/hse_pkg.sv]
`timescale 1ns / 1ps

package hse_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 8;
  localparam int TABLE_DEPTH  = 256;
  localparam int QUEUE_DEPTH  = 4;
  // longest code the table accepts
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  // up to seven pending bits in front of one code word
  localparam int ACC_W        = CODE_W + 7;
  localparam int TOT_W        = 6;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  // one queued operation for the packer
  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hse_op_t;

endpackage

[sv/hse_front.sv]
`timescale 1ns / 1ps

module hse_front import hse_pkg::*; #(
  parameter int  QDEPTH = QUEUE_DEPTH,
  localparam int CNT_W  = $clog2(QDEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_len,
  input  logic [CNT_W-1:0]  q_count,
  output logic              q_push,
  output hse_op_t           q_op
);

  logic [CODE_W+LEN_W-1:0] tbl_mem [TABLE_DEPTH];
  logic [CODE_W+LEN_W-1:0] rd_data_r;
  logic [TABLE_DEPTH-1:0]  tbl_valid_r;
  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_flush_r, s1_flush_nxt;
  logic                    accept;
  logic                    ld_ok;
  logic [CNT_W:0]          fill;
  logic [CODE_W:0]         code_mask;
  logic [CODE_W-1:0]       code_masked;

  // room is reserved for the item already in the lookup stage
  assign fill     = {1'b0, q_count} + {{CNT_W{1'b0}}, s1_valid_r};
  assign in_stall = (fill >= (CNT_W + 1)'(QDEPTH));
  assign accept   = in_valid && !in_stall;

  assign code_mask   = ((CODE_W + 1)'(1) << in_code_len) - (CODE_W + 1)'(1);
  assign code_masked = in_code_bits & code_mask[CODE_W-1:0];

  always_comb begin
    ld_ok        = 1'b0;
    s1_valid_nxt = 1'b0;
    s1_flush_nxt = 1'b0;
    case (action_t'(in_action))
      ACT_LOAD: begin
        ld_ok = accept && (in_code_len <= LEN_W'(LEN_LIMIT));
      end
      ACT_ENCODE: begin
        // misses drop here
        s1_valid_nxt = accept && tbl_valid_r[in_symbol];
      end
      ACT_FLUSH: begin
        s1_valid_nxt = accept;
        s1_flush_nxt = 1'b1;
      end
      default: begin
        ld_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_ok) begin
      tbl_mem[in_symbol] <= {in_code_len, code_masked};
    end
    rd_data_r <= tbl_mem[in_symbol];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_valid_r <= '0;
      s1_valid_r  <= 1'b0;
      s1_flush_r  <= 1'b0;
    end else begin
      if (ld_ok) begin
        tbl_valid_r[in_symbol] <= 1'b1;
      end
      s1_valid_r <= s1_valid_nxt;
      s1_flush_r <= s1_flush_nxt;
    end
  end

  assign q_push     = s1_valid_r;
  assign q_op.flush = s1_flush_r;
  assign q_op.code  = rd_data_r[CODE_W-1:0];
  assign q_op.len   = rd_data_r[CODE_W+LEN_W-1:CODE_W];

endmodule

[sv/hse_queue.sv]
`timescale 1ns / 1ps

module hse_queue import hse_pkg::*; #(
  parameter int  QDEPTH = QUEUE_DEPTH,
  localparam int CNT_W  = $clog2(QDEPTH + 1),
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hse_op_t          push_op,
  input  logic             pop,
  output hse_op_t          head_op,
  output logic [CNT_W-1:0] count
);

  hse_op_t          q_mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head_op = q_mem[rd_ptr_r];
  assign count   = count_r;

endmodule

[sv/hse_back.sv]
`timescale 1ns / 1ps

module hse_back import hse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_avail,
  input  hse_op_t    q_op,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BYTES = 3'b010,
    ST_PAD   = 3'b100
  } back_state_t;

  back_state_t      state_r, state_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             flush_r, flush_nxt;
  logic [2:0]       pad_r, pad_nxt;
  logic [6:0]       pend_bits_r, pend_bits_nxt;
  logic [2:0]       pend_cnt_r, pend_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic [ACC_W-1:0] enc_acc;
  logic [TOT_W-1:0] enc_total;
  logic [2:0]       pad3;
  logic [7:0]       fl_byte;
  logic [TOT_W-1:0] rem;
  logic [ACC_W-1:0] acc_sh;
  logic [7:0]       rem_mask;

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && q_avail;

  assign enc_acc   = (ACC_W'(pend_bits_r) << q_op.len) | ACC_W'(q_op.code);
  assign enc_total = TOT_W'(pend_cnt_r) + q_op.len;
  // pad is (8 - count) mod 8
  assign pad3      = 3'd0 - pend_cnt_r;
  assign fl_byte   = 8'(pend_bits_r) << pad3;

  assign rem       = total_r - TOT_W'(8);
  assign acc_sh    = acc_r >> rem;
  assign rem_mask  = (8'd1 << rem[2:0]) - 8'd1;

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    flush_nxt     = flush_r;
    pad_nxt       = pad_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (q_avail) begin
          if (q_op.flush) begin
            flush_nxt     = 1'b1;
            pad_nxt       = pad3;
            pend_bits_nxt = '0;
            pend_cnt_nxt  = '0;
            if (pend_cnt_r != 3'd0) begin
              acc_nxt   = ACC_W'(fl_byte);
              total_nxt = TOT_W'(8);
              state_nxt = ST_BYTES;
            end else begin
              state_nxt = ST_PAD;
            end
          end else begin
            flush_nxt = 1'b0;
            if (enc_total >= TOT_W'(8)) begin
              acc_nxt   = enc_acc;
              total_nxt = enc_total;
              state_nxt = ST_BYTES;
            end else begin
              pend_bits_nxt = enc_acc[6:0];
              pend_cnt_nxt  = enc_total[2:0];
            end
          end
        end
      end
      ST_BYTES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = acc_sh[7:0];
          out_last_nxt  = !flush_r && (rem < TOT_W'(8));
          total_nxt     = rem;
          if (rem < TOT_W'(8)) begin
            if (flush_r) begin
              state_nxt = ST_PAD;
            end else begin
              pend_bits_nxt = acc_r[6:0] & rem_mask[6:0];
              pend_cnt_nxt  = rem[2:0];
              state_nxt     = ST_IDLE;
            end
          end
        end
      end
      ST_PAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'(pad_r);
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    total_r    <= total_nxt;
    flush_r    <= flush_nxt;
    pad_r      <= pad_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

[sv/huffman_symbol_encoder_core.sv]
// an accepted encode or flush item goes through the table read register, the queue, the packer and the output register
// the packer takes no new item until an encode item has sent the bytes it completes, or a flush its pad count
// the packer pops one queued item per cycle while idle, then sends one byte per cycle while out is not stalled
// load items and table misses finish in the front end and never reach the packer
// reset (rst_n low, synchronous): clears table valid marks, queue and packer control
`timescale 1ns / 1ps

`include "huffman_symbol_encoder_core_macros.svh"

module huffman_symbol_encoder_core import hse_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // input item channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_len,
  // result item channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  localparam int CNT_W = $clog2(QDEPTH + 1);

  // front end to queue
  logic             q_push;
  hse_op_t          q_in_op;
  // queue to packer
  hse_op_t          q_head_op;
  logic             q_pop;
  logic [CNT_W-1:0] q_count;

  // front end: table writes, valid lookup, registered table read
  // items that need the packer move into the queue in the cycle after acceptance
  hse_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_symbol    (in_symbol),
    .in_code_bits (in_code_bits),
    .in_code_len  (in_code_len),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_op         (q_in_op)
  );

  // short queue so the front keeps accepting while the packer drains bytes
  hse_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_in_op),
    .pop     (q_pop),
    .head_op (q_head_op),
    .count   (q_count)
  );

  // packer: bit accumulator, byte extraction and the output register
  hse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (q_count != '0),
    .q_op      (q_head_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // the front end's reservation must keep the queue from overflowing
  `HSE_ASSERT_IMP(a_push_has_room, q_push, q_count < CNT_W'(QDEPTH))
  // the packer only pops a queue that holds an item
  `HSE_ASSERT_IMP(a_pop_not_empty, q_pop, q_count != '0)
  // a queue push follows only from an item accepted the cycle before
  `HSE_ASSERT_NXT(a_push_from_accept, !(in_valid && !in_stall), !q_push)

endmodule

[tb/sv/huffman_symbol_encoder_core_checker.sv]
`timescale 1ns / 1ps

module huffman_symbol_encoder_core_checker import hse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_len,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_byte,
  input  logic              out_last,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } packed_byte_t;

  packed_byte_t             expected_bytes [$];
  logic [CODE_W-1:0]        code_tab [TABLE_DEPTH];
  logic [LEN_W-1:0]         len_tab [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   tab_valid;
  logic [6:0]               acc_bits;
  logic [2:0]               acc_cnt;
  int                       n_out;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t, output item %0d: %s", $time, n_out, msg);
    mismatches++;
  endtask

  // bit packer prediction for one accepted item
  task automatic pack_item(input logic [1:0] act, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
    logic [ACC_W-1:0] acc;
    int               code_len;
    int               total;
    packed_byte_t     r;
    case (act)
      ACT_LOAD: begin
        if (len <= LEN_LIMIT) begin
          code_tab[sym] = CODE_W'(64'(bits) & ((64'd1 << len) - 64'd1));
          len_tab[sym] = len;
          tab_valid[sym] = 1'b1;
        end
      end
      ACT_ENCODE: begin
        if (tab_valid[sym]) begin
          code_len = int'(len_tab[sym]);
          total = int'(acc_cnt) + code_len;
          acc = (ACC_W'(acc_bits) << code_len) | ACC_W'(code_tab[sym]);
          while (total >= 8) begin
            r.data = 8'(acc >> (total - 8));
            r.is_last = (total < 16);
            expected_bytes.push_back(r);
            total -= 8;
          end
          acc_bits = 7'(64'(acc) & ((64'd1 << total) - 64'd1));
          acc_cnt = 3'(total);
        end
      end
      ACT_FLUSH: begin
        if (acc_cnt != 3'd0) begin
          r.data = 8'(int'(acc_bits) << (8 - int'(acc_cnt)));
          r.is_last = 1'b0;
          expected_bytes.push_back(r);
        end
        r.data = 8'((8 - int'(acc_cnt)) % 8);
        r.is_last = 1'b1;
        expected_bytes.push_back(r);
        acc_bits = '0;
        acc_cnt = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    packed_byte_t exp_b;
    if (!rst_n) begin
      tab_valid = '0;
      acc_bits = '0;
      acc_cnt = '0;
      expected_bytes.delete();
      mismatches = 0;
      n_out = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected item byte=%02h last=%0b", out_byte, out_last));
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_byte !== exp_b.data)
            report_mismatch($sformatf("byte %02h, expected %02h", out_byte, exp_b.data));
          if (out_last !== exp_b.is_last)
            report_mismatch($sformatf("last %0b, expected %0b", out_last, exp_b.is_last));
        end
        n_out++;
      end
      if (in_valid && !in_stall)
        pack_item(in_action, in_symbol, in_code_bits, in_code_len);
    end
    outstanding = expected_bytes.size();
  end

endmodule

[tb/sv/huffman_symbol_encoder_core_tb.sv]
`timescale 1ns / 1ps

module huffman_symbol_encoder_core_tb;
  import hse_pkg::*;

  // the action encoding leaves this value unused, the block must ignore it
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 178;
  localparam int HOLD_CYCLES  = 300;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_action;
  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_code_bits;
  logic [LEN_W-1:0]  in_code_len;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_byte;
  logic              out_last;

  int                check_errors;
  int                bytes_due;
  int                items_sent;
  // set while both sides run flat out with no gaps and no stalls
  logic              no_gaps;
  // symbols with a valid table entry, used to steer encodes onto real codes
  logic [SYM_W-1:0]  loaded_syms [$];
  logic [TABLE_DEPTH-1:0] sym_loaded;

  always #1 clk = ~clk;

  huffman_symbol_encoder_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_symbol    (in_symbol),
    .in_code_bits (in_code_bits),
    .in_code_len  (in_code_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  huffman_symbol_encoder_core_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_symbol    (in_symbol),
    .in_code_bits (in_code_bits),
    .in_code_len  (in_code_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .mismatches   (check_errors),
    .outstanding  (bytes_due)
  );

  // offer one item, with a random gap in front unless running flat out,
  // and hold it steady until the block takes it
  task automatic send_item(input logic [1:0] act, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
    while (!no_gaps && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_symbol    <= sym;
    in_code_bits <= bits;
    in_code_len  <= len;
    do @(posedge clk); while (in_stall);
    items_sent++;
    // remember which symbols now have a usable code
    if (act == ACT_LOAD && len <= LEN_LIMIT && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // result side: random stalls, none during the flat-out stretch, and one
  // long hold-off partway through so the queue fills and the input backs up
  initial begin
    int  hold_left;
    bit  hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_used && items_sent >= 150) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (no_gaps) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 34);
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #200000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int               pick;
    int               counted;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    items_sent = 0;
    no_gaps = 1'b0;
    sym_loaded = '0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= ACT_LOAD;
    in_symbol    <= '0;
    in_code_bits <= '0;
    in_code_len  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // flush with nothing pending gives a lone zero pad count
    send_item(ACT_FLUSH, 8'h00, 32'h0, 6'd0);
    // encode of a symbol that was never loaded adds nothing
    send_item(ACT_ENCODE, 8'h00, 32'h0, 6'd0);
    // zero-length code loads fine but encodes to nothing
    send_item(ACT_LOAD, 8'h00, 32'hffff_ffff, 6'd0);
    send_item(ACT_ENCODE, 8'h00, 32'h0, 6'd0);
    // longest legal code, then two over-long loads that must be dropped
    send_item(ACT_LOAD, 8'hff, 32'hffff_ffff, 6'd32);
    send_item(ACT_LOAD, 8'hff, 32'h0, 6'd33);
    send_item(ACT_LOAD, 8'hff, 32'h0, 6'd63);
    // 32 ones make four full bytes
    send_item(ACT_ENCODE, 8'hff, 32'h0, 6'd0);
    send_item(ACT_LOAD, 8'h01, 32'h5, 6'd3);
    send_item(ACT_ENCODE, 8'h01, 32'h0, 6'd0);
    // 3 pending plus 32 new bits: four bytes with 3 left over
    send_item(ACT_ENCODE, 8'hff, 32'h0, 6'd0);
    // flush with bits pending: padded byte then pad count
    send_item(ACT_FLUSH, 8'h00, 32'h0, 6'd0);
    send_item(ACT_FLUSH, 8'h00, 32'h0, 6'd0);
    // bits above the code length must be masked off
    send_item(ACT_LOAD, 8'h80, 32'haaaa_aaaa, 6'd31);
    send_item(ACT_LOAD, 8'h02, 32'hffff_fffe, 6'd1);
    send_item(ACT_ENCODE, 8'h02, 32'h0, 6'd0);
    send_item(ACT_ENCODE, 8'h80, 32'h0, 6'd0);
    // seven pending bits, the most the accumulator can hold
    send_item(ACT_LOAD, 8'h7f, 32'h7f, 6'd7);
    send_item(ACT_ENCODE, 8'h7f, 32'h0, 6'd0);
    send_item(ACT_FLUSH, 8'h00, 32'h0, 6'd0);
    // unused action code leaves everything alone
    send_item(ACT_UNUSED, 8'hff, 32'hffff_ffff, 6'd63);
    // a rejected reload keeps the old entry
    send_item(ACT_LOAD, 8'h01, 32'h0, 6'd40);
    send_item(ACT_ENCODE, 8'h01, 32'h0, 6'd0);
    send_item(ACT_ENCODE, 8'h01, 32'h0, 6'd0);
    send_item(ACT_ENCODE, 8'h01, 32'h0, 6'd0);
    send_item(ACT_FLUSH, 8'h00, 32'h0, 6'd0);

    // --- random part ---
    // mostly encodes of loaded symbols with random code content,
    // plus reloads, flushes, rejected loads and a little noise
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      no_gaps = (counted >= 60 && counted < 110);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // ignored by the block, so not counted
        send_item(ACT_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        continue;
      end
      if (pick < 22) begin
        if ($urandom_range(0, 9) == 0)
          len = LEN_W'($urandom_range(33, 63));
        else
          len = LEN_W'($urandom_range(0, 32));
        send_item(ACT_LOAD, SYM_W'($urandom), $urandom, len);
      end else if (pick < 90) begin
        if (loaded_syms.size() != 0 && $urandom_range(0, 99) < 85)
          sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        else
          sym = SYM_W'($urandom);
        // encode ignores the code fields, keep them busy anyway
        send_item(ACT_ENCODE, sym, $urandom, LEN_W'($urandom));
      end else begin
        send_item(ACT_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
      end
      counted++;
    end
    no_gaps = 1'b0;
    // final flush so the last partial byte comes out
    send_item(ACT_FLUSH, 8'h00, 32'h0, 6'd0);
    in_valid <= 1'b0;

    // drain, then give stray items time to show up
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (check_errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
